// ===== src/tpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths, constants, codes and result type of the pulse integrator.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int SAMPLE_W     = 14;   // ADC sample and baseline
    localparam int DIFF_W       = 15;   // baseline minus sample, level
    localparam int THRESH_W     = 12;
    localparam int RECORD_LENGTH = 2048;
    localparam int INDEX_W      = $clog2(RECORD_LENGTH);
    localparam int CHARGE_W     = 26;
    localparam int RUN_CHARGE_W = 27;
    localparam int WIDTH_W      = 12;
    localparam int PEAK_W       = 14;
    localparam int COUNT_W      = 32;
    localparam int PRE_MAX      = 8;
    localparam int HSUM_W       = DIFF_W + $clog2(PRE_MAX + 1);
    localparam int PRE_SAMPLES_DEFAULT = 2;

    localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(RECORD_LENGTH - 1);
    localparam logic signed [RUN_CHARGE_W-1:0] CHARGE_MAX =
        RUN_CHARGE_W'((1 << (CHARGE_W - 1)) - 1);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic signed [SAMPLE_W-1:0] BASELINE_RESET  = '0;
    localparam logic [THRESH_W-1:0]        THRESHOLD_RESET = THRESH_W'(10);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SAMPLE_W;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 120;
    localparam int FIFO_DEPTH  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASELINE  = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_CROSSING = 1'b0,
        KIND_PULSE    = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t                kind;
        logic [INDEX_W-1:0]          start_index;
        logic signed [CHARGE_W-1:0]  charge_sum;
        logic [WIDTH_W-1:0]          pulse_width;
        logic [INDEX_W-1:0]          rise_samples;
        logic [PEAK_W-1:0]           peak_height;
        logic [INDEX_W-1:0]          crossing_interval;
        logic [COUNT_W-1:0]          dark_count;
        logic                        last_of_run;
    } result_t;

    typedef struct packed {
        logic not_empty;
        logic room_for_two;
    } fifo_status_t;

endpackage

// ===== src/tpi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_core
// Per-sample pulse tracking: trigger, charge sum, peak, crossings, records.
// ----------------------------------------------------------------------------
module tpi_core import tpi_pkg::*; #(
    parameter int PRE_SAMPLES = PRE_SAMPLES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic signed [SAMPLE_W-1:0]  sample_value,
    input  logic                        record_start,
    input  logic                        record_end,
    input  logic signed [SAMPLE_W-1:0]  baseline_level,
    input  logic [THRESH_W-1:0]         trigger_threshold,
    output logic [1:0]                  res_count,
    output result_t                     res_first,
    output result_t                     res_second
);

    localparam int HIST_DEPTH = (PRE_SAMPLES > 0) ? PRE_SAMPLES : 1;

    // state
    logic                            in_pulse_reg;
    logic [INDEX_W-1:0]              idx_reg;
    logic signed [DIFF_W-1:0]        hist_reg [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0]      prev_reg;
    logic signed [RUN_CHARGE_W-1:0]  charge_reg;
    logic [WIDTH_W-1:0]              width_reg;
    logic [INDEX_W-1:0]              pstart_reg;
    logic [PEAK_W-1:0]               peak_reg;
    logic [INDEX_W-1:0]              peak_idx_reg;
    logic [INDEX_W-1:0]              last_x_reg;
    logic [COUNT_W-1:0]              total_reg;

    logic                            in_pulse_next;
    logic [INDEX_W-1:0]              idx_next;
    logic signed [RUN_CHARGE_W-1:0]  charge_next;
    logic [WIDTH_W-1:0]              width_next;
    logic [INDEX_W-1:0]              pstart_next;
    logic [PEAK_W-1:0]               peak_next;
    logic [INDEX_W-1:0]              peak_idx_next;
    logic [INDEX_W-1:0]              last_x_next;
    logic [COUNT_W-1:0]              total_next;

    // working values
    logic                            rec_begin;
    logic [INDEX_W-1:0]              idx_cur;
    logic signed [DIFF_W-1:0]        hist_cur [HIST_DEPTH];
    logic signed [DIFF_W-1:0]        prev_cur;
    logic [INDEX_W-1:0]              last_x_cur;
    logic                            in_pulse_cur;
    logic signed [DIFF_W-1:0]        s_ext;
    logic signed [DIFF_W-1:0]        base_ext;
    logic signed [DIFF_W-1:0]        level;
    logic signed [DIFF_W-1:0]        diff;
    logic                            last_sample;
    logic                            trig;
    logic                            active;
    logic                            below;
    logic                            cross_hit;
    logic                            close_pulse;
    logic signed [HSUM_W-1:0]        hsum;
    logic signed [RUN_CHARGE_W-1:0]  charge0;
    logic signed [RUN_CHARGE_W-1:0]  charge_add;
    logic [WIDTH_W-1:0]              width0;
    logic [PEAK_W-1:0]               peak0;
    logic [INDEX_W-1:0]              peak_idx0;
    result_t                         cross_res;
    result_t                         pulse_res;

    always_comb begin
        rec_begin  = record_start || (idx_reg == '0);
        idx_cur    = rec_begin ? '0 : idx_reg;
        last_x_cur = rec_begin ? '0 : last_x_reg;
        in_pulse_cur = rec_begin ? 1'b0 : in_pulse_reg;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_cur[k] = rec_begin ? '0 : hist_reg[k];
        end

        s_ext    = DIFF_W'(sample_value);
        base_ext = DIFF_W'(baseline_level);
        prev_cur = rec_begin ? base_ext : DIFF_W'(prev_reg);
        level    = base_ext - $signed({3'b000, trigger_threshold});
        diff     = base_ext - s_ext;
        last_sample = record_end || (idx_cur == INDEX_LAST);

        hsum = '0;
        for (int k = 0; k < PRE_SAMPLES; k++) begin
            hsum = hsum + HSUM_W'(hist_cur[k]);
        end

        // trigger: open a pulse, seed charge with the pre-trigger history
        trig      = !in_pulse_cur && (s_ext < level);
        active    = in_pulse_cur || trig;
        charge0   = trig ? RUN_CHARGE_W'(hsum) : charge_reg;
        width0    = trig ? WIDTH_W'(PRE_SAMPLES) : width_reg;
        pstart_next = trig ? idx_cur : pstart_reg;
        peak0     = trig ? diff[PEAK_W-1:0] : peak_reg;
        peak_idx0 = trig ? idx_cur : peak_idx_reg;

        below      = s_ext < base_ext;
        charge_add = charge0 + RUN_CHARGE_W'(diff);
        cross_hit  = active && below && (prev_cur > level) && (s_ext < level);

        charge_next   = charge0;
        width_next    = width0;
        peak_next     = peak0;
        peak_idx_next = peak_idx0;
        if (active && below) begin
            charge_next = (charge_add > CHARGE_MAX) ? CHARGE_MAX : charge_add;
            if (width0 != WIDTH_MAX) begin
                width_next = width0 + WIDTH_W'(1);
            end
            if (diff[PEAK_W-1:0] > peak0) begin
                peak_next     = diff[PEAK_W-1:0];
                peak_idx_next = idx_cur;
            end
        end

        // close on return to baseline, or on the record's last sample
        close_pulse   = active && (!below || last_sample);
        in_pulse_next = active && !close_pulse;

        total_next  = (cross_hit && total_reg != COUNT_MAX) ?
                      total_reg + COUNT_W'(1) : total_reg;
        last_x_next = cross_hit ? idx_cur : last_x_cur;
        idx_next    = last_sample ? '0 : idx_cur + INDEX_W'(1);

        cross_res.kind              = KIND_CROSSING;
        cross_res.start_index       = pstart_next;
        cross_res.charge_sum        = '0;
        cross_res.pulse_width       = '0;
        cross_res.rise_samples      = '0;
        cross_res.peak_height       = '0;
        cross_res.crossing_interval = idx_cur - last_x_cur;
        cross_res.dark_count        = total_next;
        cross_res.last_of_run       = !close_pulse;

        pulse_res.kind              = KIND_PULSE;
        pulse_res.start_index       = pstart_next;
        pulse_res.charge_sum        = charge_next[CHARGE_W-1:0];
        pulse_res.pulse_width       = width_next;
        pulse_res.rise_samples      = peak_idx_next - pstart_next;
        pulse_res.peak_height       = peak_next;
        pulse_res.crossing_interval = '0;
        pulse_res.dark_count        = total_next;
        pulse_res.last_of_run       = 1'b1;

        res_count  = step ? {1'b0, cross_hit} + {1'b0, close_pulse} : 2'd0;
        res_first  = cross_hit ? cross_res : pulse_res;
        res_second = pulse_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pulse_reg <= 1'b0;
            idx_reg      <= '0;
            total_reg    <= '0;
        end else if (step) begin
            in_pulse_reg <= in_pulse_next;
            idx_reg      <= idx_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            hist_reg[0] <= diff;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= hist_cur[k-1];
            end
            prev_reg     <= sample_value;
            charge_reg   <= charge_next;
            width_reg    <= width_next;
            pstart_reg   <= pstart_next;
            peak_reg     <= peak_next;
            peak_idx_reg <= peak_idx_next;
            last_x_reg   <= last_x_next;
        end
    end

endmodule

// ===== src/tpi_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module tpi_result_fifo import tpi_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_count,
    input  result_t       push_first,
    input  result_t       push_second,
    input  logic          pop,
    output result_t       head,
    output fifo_status_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb begin
        wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
        count_next   = count_reg + CNT_W'(push_count) - CNT_W'(pop);
        head                = mem[rd_ptr_reg];
        status.not_empty    = (count_reg != '0);
        status.room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus1] <= push_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/threshold_pulse_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_pulse_integrator
// Threshold-triggered pulse charge integrator for one digitizer channel.
// ----------------------------------------------------------------------------
// Takes one signed ADC sample per word and accepts a new word every clock
// while the result queue has room for two more results. A word is held in
// the input register, where the pulse logic works on it and writes its
// results into a four-entry result queue that drives the result stream.
// A pulse opens when a sample lies more than trigger_threshold below
// baseline_level and closes on return to baseline or at the end of the
// record (tlast, or index RECORD_LENGTH-1). A sample yields zero, one or
// two results: a crossing interval (tuser 0) and/or a finished pulse
// record (tuser 1), the crossing first; tlast marks the last result of a
// sample. The sustained rate is one sample per clock as long as the sink
// takes one result per clock; a sample with two results needs two output
// words, and the input stalls once the result queue cannot hold two more.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module threshold_pulse_integrator import tpi_pkg::*; #(
    parameter int PRE_SAMPLES = PRE_SAMPLES_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // sample stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,    // [13:0] sample_value
    input  logic                    s_tuser,    // record_start
    input  logic                    s_tlast,    // record_end
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [10:0] start_index, [36:11] charge_sum, [48:37] pulse_width,
    // [59:49] rise_samples, [73:60] peak_height, [84:74] crossing_interval,
    // [116:85] dark_count, [119:117] zero
    output logic [M_TDATA_W-1:0]    m_tdata,
    output logic                    m_tuser,    // result_kind
    output logic                    m_tlast,    // last_of_run
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // configuration registers
    logic signed [SAMPLE_W-1:0]  baseline_reg;
    logic [THRESH_W-1:0]         threshold_reg;

    // input register
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic                        rstart_reg;
    logic                        rend_reg;

    logic                        s_accept;
    logic                        step;
    logic [1:0]                  res_count;
    result_t                     res_first;
    result_t                     res_second;
    result_t                     head;
    fifo_status_t                fifo_status;

    assign cfg_ready = 1'b1;

    // hold the baseline and threshold until software writes them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= BASELINE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASELINE:  baseline_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                REG_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // process the held word only when the queue can take both results
    always_comb begin
        step          = in_valid_reg && fifo_status.room_for_two;
        s_tready      = !in_valid_reg || step;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept || (in_valid_reg && !step);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
            rstart_reg <= s_tuser;
            rend_reg   <= s_tlast;
        end
    end

    tpi_core #(
        .PRE_SAMPLES (PRE_SAMPLES)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .sample_value      (sample_reg),
        .record_start      (rstart_reg),
        .record_end        (rend_reg),
        .baseline_level    (baseline_reg),
        .trigger_threshold (threshold_reg),
        .res_count         (res_count),
        .res_first         (res_first),
        .res_second        (res_second)
    );

    tpi_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (res_count),
        .push_first  (res_first),
        .push_second (res_second),
        .pop         (m_tvalid && m_tready),
        .head        (head),
        .status      (fifo_status)
    );

    // drive the result word from the queue head
    always_comb begin
        m_tvalid = fifo_status.not_empty;
        m_tuser  = head.kind;
        m_tlast  = head.last_of_run;
        m_tdata  = {3'b000, head.dark_count, head.crossing_interval,
                    head.peak_height, head.rise_samples, head.pulse_width,
                    head.charge_sum, head.start_index};
    end

`ifndef SYNTHESIS
    // a pulse record always closes the results of its sample
    a_pulse_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PULSE) |-> m_tlast)
        else $error("pulse record without tlast");

    // a crossing word carries no charge, width or peak figures
    a_crossing_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_CROSSING) |->
        (m_tdata[36:11] == '0 && m_tdata[48:37] == '0 && m_tdata[73:60] == '0))
        else $error("crossing word with pulse fields set");

    // a closed pulse spans its pre-trigger samples plus at least one more
    a_pulse_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PULSE) |->
        (m_tdata[48:37] >= WIDTH_W'(PRE_SAMPLES + 1)))
        else $error("pulse record narrower than its pre-trigger span");

    // the dark count never goes down from one result to the next
    a_dark_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) ##1 m_tvalid |->
        (m_tdata[116:85] >= $past(m_tdata[116:85])))
        else $error("dark count decreased");
`endif

endmodule
